// ===== hdl/arpc_pkg.sv =====
// ----------------------------------------------------------------------------
// arpc_pkg
// Shared types and codes for the ARP resolver cache.
// ----------------------------------------------------------------------------
`default_nettype none

package arpc_pkg;

	// request types
	localparam logic [1:0] REQ_SEND  = 2'd0;
	localparam logic [1:0] REQ_FRAME = 2'd1;
	localparam logic [1:0] REQ_TICK  = 2'd2;

	// received frame kinds
	localparam logic [1:0] FRAME_IPV4 = 2'd0;
	localparam logic [1:0] FRAME_ARP  = 2'd1;

	// result kinds
	localparam logic [2:0] KIND_IPV4    = 3'd0;
	localparam logic [2:0] KIND_REQ     = 3'd1;
	localparam logic [2:0] KIND_REPLY   = 3'd2;
	localparam logic [2:0] KIND_DELIVER = 3'd3;
	localparam logic [2:0] KIND_DROP    = 3'd4;

	// register indexes
	localparam logic [1:0] REG_OWN_MAC  = 2'd0;
	localparam logic [1:0] REG_OWN_IP   = 2'd1;
	localparam logic [1:0] REG_LIFETIME = 2'd2;
	localparam logic [1:0] REG_HOLDOFF  = 2'd3;

	localparam logic [31:0] LIFETIME_RST = 32'd30000;
	localparam logic [31:0] HOLDOFF_RST  = 32'd5000;
	localparam logic [47:0] MAC_BCAST    = 48'hFFFF_FFFF_FFFF;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [31:0] next_hop_ip;
		logic [7:0]  dgram_tag;
		logic [47:0] frame_dst_mac;
		logic [1:0]  frame_kind;
		logic        arp_is_request;
		logic [31:0] sender_ip;
		logic [47:0] sender_mac;
		logic [31:0] target_ip;
		logic        parse_error;
		logic [31:0] elapsed_ms;
	} req_t;

	typedef struct packed {
		logic [2:0]  out_kind;
		logic [47:0] dst_mac;
		logic [31:0] arp_target_ip;
		logic [7:0]  out_tag;
		logic        last;
	} res_t;

	typedef struct packed {
		logic [47:0] own_mac;
		logic [31:0] own_ip;
		logic [31:0] cache_lifetime_ms;
		logic [31:0] request_holdoff_ms;
	} cfg_t;

	typedef enum logic [2:0] {
		OP_NONE  = 3'd0,
		OP_CSCAN = 3'd1,
		OP_RSCAN = 3'd2,
		OP_COUNT = 3'd3,
		OP_FLUSH = 3'd4,
		OP_AGEC  = 3'd5,
		OP_AGER  = 3'd6
	} op_t;

	typedef enum logic [2:0] {
		SEL_HIT     = 3'd0,
		SEL_DROP    = 3'd1,
		SEL_REQ     = 3'd2,
		SEL_REPLY   = 3'd3,
		SEL_DELIVER = 3'd4,
		SEL_FLUSH   = 3'd5
	} res_sel_t;

	typedef struct packed {
		logic     load;
		op_t      op;
		logic     step;
		logic     emit;
		res_sel_t sel;
		logic     learn_wr;
		logic     rec_wr;
		logic     append;
	} cmd_t;

	typedef struct packed {
		logic [1:0] req_type;
		logic       deliver_ok;
		logic       arp_ok;
		logic       is_req;
		logic       cache_hit;
		logic       req_out;
		logic       pend_full;
		logic       pend_empty;
		logic       idx_done;
		logic       flush_hit;
		logic       out_free;
	} sts_t;

endpackage

`default_nettype wire

// ===== hdl/arpc_ifs.sv =====
// ----------------------------------------------------------------------------
// arpc_ifs
// Valid/ready channels for request and result transactions.
// ----------------------------------------------------------------------------
`default_nettype none

interface arpc_req_if;
	logic          valid;
	logic          ready;
	arpc_pkg::req_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface arpc_res_if;
	logic          valid;
	logic          ready;
	arpc_pkg::res_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== hdl/arp_resolver_cache.sv =====
// ----------------------------------------------------------------------------
// arp_resolver_cache
// ARP resolver: next-hop cache, outstanding request table, pending queue.
// ----------------------------------------------------------------------------
// One transaction at a time is processed; req.ready is high only while the
// sequencer is idle, and results leave through a single output register so
// a new transaction can be taken while the last result waits. Table scans
// step one entry per cycle, but the pending flush holds a matching entry
// until the output register is free. A send scans the cache and, on a miss,
// the request table; an ARP message counts matching pending entries, scans
// the cache, learns the sender and flushes the pending queue; a tick ages
// both tables. An emit waits while res.ready leaves a result in the output
// register. Configuration is a 64-bit APB port, register i at byte address
// 8*i, to be written only while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module arp_resolver_cache #(
	parameter int CACHE_ENTRIES   = 16,
	parameter int REQUEST_ENTRIES = 16,
	parameter int PENDING_DEPTH   = 16
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         psel,
	input  wire         penable,
	input  wire         pwrite,
	input  wire  [4:0]  paddr,
	input  wire  [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready,
	arpc_req_if.sink    req,
	arpc_res_if.source  res
);
	import arpc_pkg::*;

	cfg_t cfg_q;
	cmd_t cmd;
	sts_t sts;
	logic [1:0] reg_idx;

	assign reg_idx = paddr[4:3];
	assign pready  = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.own_mac            <= '0;
			cfg_q.own_ip             <= '0;
			cfg_q.cache_lifetime_ms  <= LIFETIME_RST;
			cfg_q.request_holdoff_ms <= HOLDOFF_RST;
		end else if (psel && penable && pwrite) begin
			case (reg_idx)
				REG_OWN_MAC:  cfg_q.own_mac            <= pwdata[47:0];
				REG_OWN_IP:   cfg_q.own_ip             <= pwdata[31:0];
				REG_LIFETIME: cfg_q.cache_lifetime_ms  <= pwdata[31:0];
				REG_HOLDOFF:  cfg_q.request_holdoff_ms <= pwdata[31:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_OWN_MAC:  prdata = {16'd0, cfg_q.own_mac};
			REG_OWN_IP:   prdata = {32'd0, cfg_q.own_ip};
			REG_LIFETIME: prdata = {32'd0, cfg_q.cache_lifetime_ms};
			REG_HOLDOFF:  prdata = {32'd0, cfg_q.request_holdoff_ms};
			default:      prdata = '0;
		endcase
	end

	arpc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	arpc_dp #(
		.CACHE_ENTRIES   (CACHE_ENTRIES),
		.REQUEST_ENTRIES (REQUEST_ENTRIES),
		.PENDING_DEPTH   (PENDING_DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_data   (req.data),
		.cmd       (cmd),
		.sts       (sts),
		.res_valid (res.valid),
		.res_ready (res.ready),
		.res_data  (res.data)
	);

	// one transaction in flight: no accept right after an accept
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !req.ready)
		else $error("request accepted while busy");

	a_kind_legal: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> res.data.out_kind <= KIND_DROP)
		else $error("illegal result kind");

	a_bcast_req: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.data.out_kind == KIND_REQ |->
			res.data.dst_mac == MAC_BCAST && res.data.out_tag == 8'd0)
		else $error("ARP request not broadcast");

endmodule

`default_nettype wire

// ===== hdl/arpc_dp.sv =====
// ----------------------------------------------------------------------------
// arpc_dp
// Cache, request and pending tables with their scan unit and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module arpc_dp #(
	parameter int CACHE_ENTRIES   = 16,
	parameter int REQUEST_ENTRIES = 16,
	parameter int PENDING_DEPTH   = 16
) (
	input  wire             clk,
	input  wire             arst_n,
	input  arpc_pkg::cfg_t  cfg,
	input  arpc_pkg::req_t  in_data,
	input  arpc_pkg::cmd_t  cmd,
	output arpc_pkg::sts_t  sts,
	output logic            res_valid,
	input  wire             res_ready,
	output arpc_pkg::res_t  res_data
);
	import arpc_pkg::*;

	localparam int CW  = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
	localparam int RW  = (REQUEST_ENTRIES > 1) ? $clog2(REQUEST_ENTRIES) : 1;
	localparam int PW  = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
	localparam int PCW = $clog2(PENDING_DEPTH + 1);
	localparam int IW0 = (CW > RW) ? CW : RW;
	localparam int IW  = (IW0 > PW) ? IW0 : PW;

	req_t          item_q;
	logic [IW-1:0] idx_q;

	logic        cvalid_q [CACHE_ENTRIES];
	logic [31:0] cip_q    [CACHE_ENTRIES];
	logic [47:0] cmac_q   [CACHE_ENTRIES];
	logic [31:0] cage_q   [CACHE_ENTRIES];
	logic        rvalid_q [REQUEST_ENTRIES];
	logic [31:0] rip_q    [REQUEST_ENTRIES];
	logic [31:0] rage_q   [REQUEST_ENTRIES];
	logic [PCW-1:0] pcount_q;
	logic [31:0] pip_q    [PENDING_DEPTH];
	logic [7:0]  ph_q     [PENDING_DEPTH];

	logic          hit_found_q, cfree_found_q, rout_q, rfree_found_q;
	logic [CW-1:0] hit_idx_q, cfree_idx_q, cold_idx_q;
	logic [47:0]   hit_mac_q;
	logic [31:0]   cold_age_q, rold_age_q;
	logic [RW-1:0] rfree_idx_q, rold_idx_q;
	logic [PCW-1:0] mcnt_q, wp_q;

	logic   res_valid_q;
	res_t   res_q;

	logic [CW-1:0] ci;
	logic [RW-1:0] ri;
	logic [PW-1:0] pi;
	logic [32:0]   csum, rsum;
	logic [31:0]   cage_new, rage_new, look_ip;
	logic          cmatch, rmatch, pmatch, cfirst, rfirst;
	logic          cdone, rdone, pdone, out_free;
	logic [CW-1:0] learn_slot;
	logic [RW-1:0] rec_slot;
	res_t          res_next;

	assign ci = idx_q[CW-1:0];
	assign ri = idx_q[RW-1:0];
	assign pi = idx_q[PW-1:0];

	assign look_ip  = (item_q.req_type == REQ_SEND) ? item_q.next_hop_ip : item_q.sender_ip;
	assign cmatch   = cvalid_q[ci] && (cip_q[ci] == look_ip);
	assign rmatch   = rvalid_q[ri] && (rip_q[ri] == item_q.next_hop_ip);
	assign pmatch   = pip_q[pi] == item_q.sender_ip;
	assign cfirst   = ci == '0;
	assign rfirst   = ri == '0;

	// saturating age update
	assign csum     = {1'b0, cage_q[ci]} + {1'b0, item_q.elapsed_ms};
	assign rsum     = {1'b0, rage_q[ri]} + {1'b0, item_q.elapsed_ms};
	assign cage_new = csum[32] ? '1 : csum[31:0];
	assign rage_new = rsum[32] ? '1 : rsum[31:0];

	assign cdone = ci == CW'(CACHE_ENTRIES - 1);
	assign rdone = ri == RW'(REQUEST_ENTRIES - 1);
	assign pdone = PCW'(pi) == (pcount_q - PCW'(1));

	assign learn_slot = hit_found_q ? hit_idx_q : (cfree_found_q ? cfree_idx_q : cold_idx_q);
	assign rec_slot   = rfree_found_q ? rfree_idx_q : rold_idx_q;

	assign out_free = !res_valid_q || res_ready;

	always_comb begin
		logic frame_ok;
		frame_ok = ((item_q.frame_dst_mac == MAC_BCAST) ||
			(item_q.frame_dst_mac == cfg.own_mac)) && !item_q.parse_error;
		sts.req_type   = item_q.req_type;
		sts.deliver_ok = frame_ok && (item_q.frame_kind == FRAME_IPV4);
		sts.arp_ok     = frame_ok && (item_q.frame_kind == FRAME_ARP) &&
			(!item_q.arp_is_request || (item_q.target_ip == cfg.own_ip));
		sts.is_req     = item_q.arp_is_request;
		sts.cache_hit  = hit_found_q;
		sts.req_out    = rout_q;
		sts.pend_full  = pcount_q == PCW'(PENDING_DEPTH);
		sts.pend_empty = pcount_q == '0;
		sts.flush_hit  = pmatch;
		sts.out_free   = out_free;
		case (cmd.op)
			OP_CSCAN, OP_AGEC: sts.idx_done = cdone;
			OP_RSCAN, OP_AGER: sts.idx_done = rdone;
			OP_COUNT, OP_FLUSH: sts.idx_done = pdone;
			default: sts.idx_done = 1'b0;
		endcase
	end

	always_comb begin
		res_next = '0;
		case (cmd.sel)
			SEL_HIT: begin
				res_next.out_kind = KIND_IPV4;
				res_next.dst_mac  = hit_mac_q;
				res_next.out_tag  = item_q.dgram_tag;
				res_next.last     = 1'b1;
			end
			SEL_DROP: begin
				res_next.out_kind = KIND_DROP;
				res_next.out_tag  = item_q.dgram_tag;
				res_next.last     = rout_q;
			end
			SEL_REQ: begin
				res_next.out_kind      = KIND_REQ;
				res_next.dst_mac       = MAC_BCAST;
				res_next.arp_target_ip = item_q.next_hop_ip;
				res_next.last          = 1'b1;
			end
			SEL_REPLY: begin
				res_next.out_kind      = KIND_REPLY;
				res_next.dst_mac       = item_q.sender_mac;
				res_next.arp_target_ip = item_q.sender_ip;
				res_next.last          = mcnt_q == '0;
			end
			SEL_DELIVER: begin
				res_next.out_kind = KIND_DELIVER;
				res_next.out_tag  = item_q.dgram_tag;
				res_next.last     = 1'b1;
			end
			SEL_FLUSH: begin
				res_next.out_kind = KIND_IPV4;
				res_next.dst_mac  = item_q.sender_mac;
				res_next.out_tag  = ph_q[pi];
				res_next.last     = mcnt_q == PCW'(1);
			end
			default: res_next = '0;
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q         <= '0;
			pcount_q      <= '0;
			wp_q          <= '0;
			mcnt_q        <= '0;
			hit_found_q   <= 1'b0;
			cfree_found_q <= 1'b0;
			rout_q        <= 1'b0;
			rfree_found_q <= 1'b0;
			res_valid_q   <= 1'b0;
			for (int i = 0; i < CACHE_ENTRIES; i++) cvalid_q[i] <= 1'b0;
			for (int i = 0; i < REQUEST_ENTRIES; i++) rvalid_q[i] <= 1'b0;
		end else begin
			if (cmd.load) begin
				mcnt_q <= '0;
				wp_q   <= '0;
			end
			if (cmd.step) begin
				idx_q <= sts.idx_done ? '0 : idx_q + IW'(1);
			end
			if (cmd.step && cmd.op == OP_CSCAN) begin
				hit_found_q   <= (cfirst ? 1'b0 : hit_found_q) | cmatch;
				cfree_found_q <= (cfirst ? 1'b0 : cfree_found_q) | !cvalid_q[ci];
			end
			if (cmd.step && cmd.op == OP_RSCAN) begin
				rout_q        <= (rfirst ? 1'b0 : rout_q) | rmatch;
				rfree_found_q <= (rfirst ? 1'b0 : rfree_found_q) | !rvalid_q[ri];
			end
			if (cmd.step && cmd.op == OP_COUNT && pmatch) begin
				mcnt_q <= mcnt_q + PCW'(1);
			end
			if (cmd.step && cmd.op == OP_FLUSH) begin
				if (pmatch) mcnt_q <= mcnt_q - PCW'(1);
				else wp_q <= wp_q + PCW'(1);
				if (pdone) pcount_q <= wp_q + PCW'(!pmatch);
			end
			if (cmd.step && cmd.op == OP_AGEC && cvalid_q[ci] &&
					cage_new >= cfg.cache_lifetime_ms) begin
				cvalid_q[ci] <= 1'b0;
			end
			if (cmd.step && cmd.op == OP_AGER && rvalid_q[ri] &&
					rage_new >= cfg.request_holdoff_ms) begin
				rvalid_q[ri] <= 1'b0;
			end
			if (cmd.learn_wr) cvalid_q[learn_slot] <= 1'b1;
			if (cmd.rec_wr) rvalid_q[rec_slot] <= 1'b1;
			if (cmd.append) pcount_q <= pcount_q + PCW'(1);
			if (cmd.emit) res_valid_q <= 1'b1;
			else if (res_ready) res_valid_q <= 1'b0;
		end
	end

	// table payload and scan trackers
	always_ff @(posedge clk) begin
		if (cmd.load) item_q <= in_data;
		if (cmd.step && cmd.op == OP_CSCAN) begin
			if (cmatch && (cfirst || !hit_found_q)) begin
				hit_idx_q <= ci;
				hit_mac_q <= cmac_q[ci];
			end
			if (!cvalid_q[ci] && (cfirst || !cfree_found_q)) cfree_idx_q <= ci;
			// oldest entry, lowest index on ties
			if (cfirst || cage_q[ci] > cold_age_q) begin
				cold_idx_q <= ci;
				cold_age_q <= cage_q[ci];
			end
		end
		if (cmd.step && cmd.op == OP_RSCAN) begin
			if (!rvalid_q[ri] && (rfirst || !rfree_found_q)) rfree_idx_q <= ri;
			if (rfirst || rage_q[ri] > rold_age_q) begin
				rold_idx_q <= ri;
				rold_age_q <= rage_q[ri];
			end
		end
		if (cmd.step && cmd.op == OP_FLUSH && !pmatch) begin
			pip_q[wp_q[PW-1:0]] <= pip_q[pi];
			ph_q[wp_q[PW-1:0]]  <= ph_q[pi];
		end
		if (cmd.step && cmd.op == OP_AGEC && cvalid_q[ci]) cage_q[ci] <= cage_new;
		if (cmd.step && cmd.op == OP_AGER && rvalid_q[ri]) rage_q[ri] <= rage_new;
		if (cmd.learn_wr) begin
			cip_q[learn_slot]  <= item_q.sender_ip;
			cmac_q[learn_slot] <= item_q.sender_mac;
			cage_q[learn_slot] <= '0;
		end
		if (cmd.rec_wr) begin
			rip_q[rec_slot]  <= item_q.next_hop_ip;
			rage_q[rec_slot] <= '0;
		end
		if (cmd.append) begin
			pip_q[pcount_q[PW-1:0]] <= item_q.next_hop_ip;
			ph_q[pcount_q[PW-1:0]]  <= item_q.dgram_tag;
		end
		if (cmd.emit) res_q <= res_next;
	end

	assign res_valid = res_valid_q;
	assign res_data  = res_q;

endmodule

`default_nettype wire

// ===== hdl/arpc_ctrl.sv =====
// ----------------------------------------------------------------------------
// arpc_ctrl
// Sequencer that walks each transaction through table scans and emits.
// ----------------------------------------------------------------------------
`default_nettype none

module arpc_ctrl (
	input  wire            clk,
	input  wire            arst_n,
	input  wire            in_valid,
	output logic           in_ready,
	input  arpc_pkg::sts_t sts,
	output arpc_pkg::cmd_t cmd
);
	import arpc_pkg::*;

	typedef enum logic [15:0] {
		ST_IDLE    = 16'h0001,
		ST_DECODE  = 16'h0002,
		ST_CSCAN   = 16'h0004,
		ST_HIT     = 16'h0008,
		ST_RSCAN   = 16'h0010,
		ST_APPEND  = 16'h0020,
		ST_DROP    = 16'h0040,
		ST_REQ     = 16'h0080,
		ST_DELIVER = 16'h0100,
		ST_COUNT   = 16'h0200,
		ST_REPLY   = 16'h0400,
		ST_LSCAN   = 16'h0800,
		ST_LEARN   = 16'h1000,
		ST_FLUSH   = 16'h2000,
		ST_AGEC    = 16'h4000,
		ST_AGER    = 16'h8000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		cmd.op   = OP_NONE;
		cmd.sel  = SEL_HIT;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_DECODE;
				end
			end
			ST_DECODE: begin
				case (sts.req_type)
					REQ_SEND: state_d = ST_CSCAN;
					REQ_FRAME: begin
						if (sts.deliver_ok) state_d = ST_DELIVER;
						else if (sts.arp_ok) begin
							if (!sts.pend_empty) state_d = ST_COUNT;
							else if (sts.is_req) state_d = ST_REPLY;
							else state_d = ST_LSCAN;
						end else state_d = ST_IDLE;
					end
					REQ_TICK: state_d = ST_AGEC;
					default: state_d = ST_IDLE;
				endcase
			end
			ST_CSCAN: begin
				cmd.op   = OP_CSCAN;
				cmd.step = 1'b1;
				if (sts.idx_done) state_d = ST_HIT;
			end
			ST_HIT: begin
				cmd.sel = SEL_HIT;
				if (!sts.cache_hit) state_d = ST_RSCAN;
				else if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			ST_RSCAN: begin
				cmd.op   = OP_RSCAN;
				cmd.step = 1'b1;
				if (sts.idx_done) state_d = ST_APPEND;
			end
			ST_APPEND: begin
				cmd.append = !sts.pend_full;
				if (sts.pend_full) state_d = ST_DROP;
				else if (sts.req_out) state_d = ST_IDLE;
				else state_d = ST_REQ;
			end
			ST_DROP: begin
				cmd.sel = SEL_DROP;
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d  = sts.req_out ? ST_IDLE : ST_REQ;
				end
			end
			ST_REQ: begin
				cmd.sel = SEL_REQ;
				if (sts.out_free) begin
					cmd.emit   = 1'b1;
					cmd.rec_wr = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			ST_DELIVER: begin
				cmd.sel = SEL_DELIVER;
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			ST_COUNT: begin
				cmd.op   = OP_COUNT;
				cmd.step = 1'b1;
				if (sts.idx_done) state_d = sts.is_req ? ST_REPLY : ST_LSCAN;
			end
			ST_REPLY: begin
				cmd.sel = SEL_REPLY;
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_LSCAN;
				end
			end
			ST_LSCAN: begin
				cmd.op   = OP_CSCAN;
				cmd.step = 1'b1;
				if (sts.idx_done) state_d = ST_LEARN;
			end
			ST_LEARN: begin
				cmd.learn_wr = 1'b1;
				state_d      = sts.pend_empty ? ST_IDLE : ST_FLUSH;
			end
			ST_FLUSH: begin
				cmd.op  = OP_FLUSH;
				cmd.sel = SEL_FLUSH;
				// a matching entry waits for the result register
				if (!sts.flush_hit || sts.out_free) begin
					cmd.step = 1'b1;
					cmd.emit = sts.flush_hit;
					if (sts.idx_done) state_d = ST_IDLE;
				end
			end
			ST_AGEC: begin
				cmd.op   = OP_AGEC;
				cmd.step = 1'b1;
				if (sts.idx_done) state_d = ST_AGER;
			end
			ST_AGER: begin
				cmd.op   = OP_AGER;
				cmd.step = 1'b1;
				if (sts.idx_done) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

endmodule

`default_nettype wire
